// ===== rtl/core/ptes_pkg.sv =====
package ptes_pkg;

	localparam int REQ_W      = 3;
	localparam int TASK_IDX_W = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int PERIOD_W   = 32;
	localparam int FLAGS_W    = 5;

	localparam int NUM_PERIOD_REGS = 5;

	localparam logic [REQ_W-1:0] REQ_TICK      = 3'd0;
	localparam logic [REQ_W-1:0] REQ_FORCE_ONE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR_ONE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_FORCE_ALL = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR_ALL = 3'd4;

	localparam logic [PERIOD_W-1:0] PERIOD_RST [NUM_PERIOD_REGS] = '{
		32'd200, 32'd4000, 32'd100, 32'd250, 32'd9000
	};

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

endpackage

// ===== rtl/core/ptes_elapsed_cmp.sv =====
module ptes_elapsed_cmp #(
	parameter int TIME_WIDTH = 32
) (
	input  logic [TIME_WIDTH-1:0]         now,
	input  logic [TIME_WIDTH-1:0]         anchor,
	input  logic [ptes_pkg::PERIOD_W-1:0] period,
	output logic                          hit
);
	import ptes_pkg::*;

	localparam int CMP_W = (TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W;

	logic [TIME_WIDTH-1:0] elapsed;

	// wrapping elapsed time, compared against the period at the wider width
	assign elapsed = now - anchor;
	assign hit = CMP_W'(elapsed) >= CMP_W'(period);

endmodule

// ===== rtl/core/periodic_task_event_scheduler_unit.sv =====
// Tick item: ST_SCAN checks every task, then done strobes in ST_DONE; busy until back in ST_IDLE.
// Other items: done strobes in the cycle after accept; a new start is taken in ST_IDLE only.
// One shared subtract/compare unit visits one task per cycle during the tick scan.
// Results are shown on event_flags for the single done cycle; the receiver cannot stall.
// Reset (arst_n low) clears time, anchors and flags and restores default periods.
module periodic_task_event_scheduler_unit #(
	parameter int NUM_TASKS  = 5,
	parameter int TIME_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ptes_pkg::REQ_W-1:0]     req_type,
	input  logic [ptes_pkg::TASK_IDX_W-1:0] task_index,
	output logic                           done,
	output logic [ptes_pkg::FLAGS_W-1:0]   event_flags,
	input  logic                           cfg_we,
	input  logic [ptes_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ptes_pkg::PERIOD_W-1:0]  cfg_data
);
	import ptes_pkg::*;

	localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	state_t                state_q;
	logic [TIME_WIDTH-1:0] time_q;
	logic [TIME_WIDTH-1:0] anchor_q [NUM_TASKS];
	logic [PERIOD_W-1:0]   period_q [NUM_TASKS];
	logic [NUM_TASKS-1:0]  flag_q;
	logic [IDX_W-1:0]      scan_q;

	logic                  idx_ok;
	logic [IDX_W-1:0]      tsel;
	logic                  hit;

	assign idx_ok = (task_index != '0) &&
		(int'(task_index) <= NUM_TASKS);
	assign tsel = IDX_W'(task_index - TASK_IDX_W'(1));

	ptes_elapsed_cmp #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_cmp (
		.now    (time_q),
		.anchor (anchor_q[scan_q]),
		.period (period_q[scan_q]),
		.hit    (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TASKS; t++) begin
				period_q[t] <= (t < NUM_PERIOD_REGS) ? PERIOD_RST[t] : '0;
			end
		end else if (cfg_we) begin
			for (int t = 0; t < NUM_TASKS; t++) begin
				if ((t < NUM_PERIOD_REGS) && (cfg_index == CFG_IDX_W'(t))) begin
					period_q[t] <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			time_q  <= '0;
			flag_q  <= '0;
			scan_q  <= '0;
			for (int t = 0; t < NUM_TASKS; t++) begin
				anchor_q[t] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= (req_type == REQ_TICK) ? ST_SCAN : ST_DONE;
						case (req_type)
							REQ_TICK: begin
								time_q <= time_q + TIME_WIDTH'(1);
								scan_q <= '0;
							end
							REQ_FORCE_ONE: begin
								if (idx_ok) begin
									flag_q[tsel] <= 1'b1;
								end
							end
							REQ_CLEAR_ONE: begin
								if (idx_ok) begin
									flag_q[tsel]   <= 1'b0;
									anchor_q[tsel] <= time_q;
								end
							end
							REQ_FORCE_ALL, REQ_CLEAR_ALL: begin
								flag_q <= (req_type == REQ_FORCE_ALL) ? '1 : '0;
								for (int t = 0; t < NUM_TASKS; t++) begin
									anchor_q[t] <= time_q;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					// one task per cycle through the shared compare
					if (!flag_q[scan_q] && hit) begin
						flag_q[scan_q] <= 1'b1;
					end
					if (scan_q == IDX_W'(NUM_TASKS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	always_comb begin
		event_flags = '0;
		for (int b = 0; b < FLAGS_W; b++) begin
			if (b < NUM_TASKS) begin
				event_flags[b] = flag_q[b];
			end
		end
	end

endmodule

// ===== test/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ptes_pkg::*;

	localparam int NUM_TASKS   = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 212;

	// request codes the block leaves unused
	localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [REQ_W-1:0]      req_type = '0;
	logic [TASK_IDX_W-1:0] task_index = '0;
	logic                  done;
	logic [FLAGS_W-1:0]    event_flags;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [PERIOD_W-1:0]   cfg_data = '0;

	periodic_task_event_scheduler_unit #(
		.NUM_TASKS (NUM_TASKS),
		.TIME_WIDTH(32)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.task_index (task_index),
		.done       (done),
		.event_flags(event_flags),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scheduler state as the block should hold it
	logic [31:0]         sched_time;
	logic [31:0]         sched_anchor [NUM_TASKS];
	logic                sched_pending [NUM_TASKS];
	logic [PERIOD_W-1:0] sched_period [NUM_TASKS];

	logic [FLAGS_W-1:0] flags_pending_q [$];
	int error_count = 0;
	int cycle_count = 0;

	typedef struct packed {
		logic [REQ_W-1:0]      rq;
		logic [TASK_IDX_W-1:0] ix;
		logic                  typed;
		logic [FLAGS_W-1:0]    flags;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 21;
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{REQ_TICK,      3'd0, 1'b1, 5'b00000},
		'{REQ_TICK,      3'd7, 1'b1, 5'b00000},
		'{REQ_FORCE_ONE, 3'd1, 1'b1, 5'b00001},
		'{REQ_FORCE_ONE, 3'd5, 1'b1, 5'b10001},
		'{REQ_FORCE_ONE, 3'd0, 1'b1, 5'b10001},
		'{REQ_FORCE_ONE, 3'd6, 1'b1, 5'b10001},
		'{REQ_FORCE_ONE, 3'd7, 1'b1, 5'b10001},
		'{REQ_CLEAR_ONE, 3'd1, 1'b1, 5'b10000},
		'{REQ_CLEAR_ONE, 3'd0, 1'b1, 5'b10000},
		'{REQ_CLEAR_ONE, 3'd7, 1'b1, 5'b10000},
		'{REQ_SPARE_A,   3'd3, 1'b1, 5'b10000},
		'{REQ_SPARE_B,   3'd1, 1'b1, 5'b10000},
		'{REQ_SPARE_C,   3'd5, 1'b1, 5'b10000},
		'{REQ_FORCE_ALL, 3'd2, 1'b1, 5'b11111},
		'{REQ_TICK,      3'd0, 1'b1, 5'b11111},
		'{REQ_CLEAR_ONE, 3'd5, 1'b1, 5'b01111},
		'{REQ_CLEAR_ALL, 3'd4, 1'b1, 5'b00000},
		'{REQ_FORCE_ONE, 3'd3, 1'b1, 5'b00100},
		'{REQ_CLEAR_ONE, 3'd3, 1'b1, 5'b00000},
		'{REQ_TICK,      3'd0, 1'b0, 5'b00000},
		'{REQ_TICK,      3'd6, 1'b0, 5'b00000}
	};

	function automatic void reset_schedule();
		sched_time = '0;
		for (int t = 0; t < NUM_TASKS; t++) begin
			sched_anchor[t]  = '0;
			sched_pending[t] = 1'b0;
			sched_period[t]  = PERIOD_RST[t];
		end
	endfunction

	function automatic logic [FLAGS_W-1:0] next_event_flags(input logic [REQ_W-1:0] rq,
			input logic [TASK_IDX_W-1:0] ix);
		logic               idx_ok;
		logic [FLAGS_W-1:0] flags;
		idx_ok = (ix >= 1) && (ix <= NUM_TASKS);
		case (rq)
			REQ_TICK: begin
				sched_time = sched_time + 32'd1;
				for (int t = 0; t < NUM_TASKS; t++)
					if (!sched_pending[t] && (sched_time - sched_anchor[t]) >= sched_period[t])
						sched_pending[t] = 1'b1;
			end
			REQ_FORCE_ONE: begin
				if (idx_ok)
					sched_pending[ix-1] = 1'b1;
			end
			REQ_CLEAR_ONE: begin
				if (idx_ok) begin
					sched_pending[ix-1] = 1'b0;
					sched_anchor[ix-1]  = sched_time;
				end
			end
			REQ_FORCE_ALL, REQ_CLEAR_ALL: begin
				for (int t = 0; t < NUM_TASKS; t++) begin
					sched_pending[t] = (rq == REQ_FORCE_ALL);
					sched_anchor[t]  = sched_time;
				end
			end
			default: ;
		endcase
		flags = '0;
		for (int t = 0; t < NUM_TASKS && t < FLAGS_W; t++)
			flags[t] = sched_pending[t];
		return flags;
	endfunction

	task automatic report_error(input string what, input logic [FLAGS_W-1:0] got,
			input logic [FLAGS_W-1:0] want);
		if (error_count < 40)
			$display("%0t ns: %s: event_flags %b, expected %b", $realtime, what, got, want);
		error_count++;
	endtask

	// start stays high after the accepting edge; the caller either sends again or lowers it
	task automatic send_item(input logic [REQ_W-1:0] rq, input logic [TASK_IDX_W-1:0] ix,
			input logic typed, input logic [FLAGS_W-1:0] typed_flags);
		logic [FLAGS_W-1:0] predicted;
		start      <= 1'b1;
		req_type   <= rq;
		task_index <= ix;
		do @(posedge clk); while (busy);
		predicted = next_event_flags(rq, ix);
		flags_pending_q.push_back(typed ? typed_flags : predicted);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (flags_pending_q.size() != 0 || busy);
	endtask

	// cfg_we is lowered by the caller once a batch of writes is through
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx < NUM_PERIOD_REGS && idx < NUM_TASKS)
			sched_period[idx] = value;
	endtask

	task automatic run_random(input int count, input int gap_pct, input bit mixed);
		int                    w;
		int                    pct;
		logic [REQ_W-1:0]      rq;
		logic [TASK_IDX_W-1:0] ix;
		for (int n = 0; n < count; n++) begin
			pct = (mixed && ((n / 40) % 2 == 1)) ? 65 : gap_pct;
			while ($urandom_range(99) < pct) begin
				start <= 1'b0;
				@(posedge clk);
			end
			if (pct != 0 && $urandom_range(99) < 2)
				drain_results();
			w = $urandom_range(99);
			// mostly ticks with the pending events serviced, plus some noise
			if (w < 58) begin
				rq = REQ_TICK;
				ix = TASK_IDX_W'($urandom_range(7));
			end else if (w < 73) begin
				rq = REQ_CLEAR_ONE;
				ix = TASK_IDX_W'($urandom_range(NUM_TASKS, 1));
			end else if (w < 79) begin
				rq = REQ_FORCE_ONE;
				ix = TASK_IDX_W'($urandom_range(NUM_TASKS, 1));
			end else if (w < 82) begin
				rq = REQ_FORCE_ALL;
				ix = TASK_IDX_W'($urandom_range(7));
			end else if (w < 86) begin
				rq = REQ_CLEAR_ALL;
				ix = TASK_IDX_W'($urandom_range(7));
			end else begin
				rq = REQ_W'($urandom_range(7));
				ix = TASK_IDX_W'($urandom_range(7));
			end
			send_item(rq, ix, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (flags_pending_q.size() == 0)
				report_error("result with none outstanding", event_flags, 'x);
			else if (event_flags !== flags_pending_q[0])
				report_error("flags mismatch", event_flags, flags_pending_q.pop_front());
			else
				void'(flags_pending_q.pop_front());
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("periodic_task_event_scheduler_unit regression: fail");
			$finish;
		end
	end

	initial begin
		logic [PERIOD_W-1:0] periods [NUM_TASKS];
		int gap_pct;
		bit mixed;
		reset_schedule();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_item(directed_rows[r].rq, directed_rows[r].ix, directed_rows[r].typed,
				directed_rows[r].flags);

		for (int phase = 1; phase <= 4; phase++) begin
			drain_results();
			mixed = 1'b0;
			case (phase)
				1: begin
					periods = '{32'd0, 32'd1, 32'd3, 32'd7, 32'd15};
					gap_pct = 0;
				end
				2: begin
					for (int t = 0; t < NUM_TASKS; t++)
						periods[t] = $urandom_range(12);
					gap_pct = 65;
				end
				3: begin
					periods = '{32'hFFFF_FFFF, 32'd0, 32'd2, 32'hFFFF_FFFE, 32'd1};
					gap_pct = 9;
				end
				default: begin
					for (int t = 0; t < NUM_TASKS; t++)
						periods[t] = $urandom_range(40);
					gap_pct = 0;
					mixed = 1'b1;
				end
			endcase
			for (int t = 0; t < NUM_TASKS; t++)
				write_reg(CFG_IDX_W'(t), periods[t]);
			// indexes past the period registers must be ignored
			if (phase == 1 || phase == 3)
				for (int i = NUM_PERIOD_REGS; i < 8; i++)
					write_reg(CFG_IDX_W'(i), phase == 1 ? PERIOD_W'($urandom) : '1);
			cfg_we <= 1'b0;
			run_random(ITEMS_PER_PHASE, gap_pct, mixed);
		end

		start <= 1'b0;
		while (flags_pending_q.size() != 0)
			@(posedge clk);
		repeat (NUM_TASKS + 4) @(posedge clk);
		if (error_count == 0)
			$display("periodic_task_event_scheduler_unit regression: pass");
		else
			$display("periodic_task_event_scheduler_unit regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/ptes_pkg.sv
rtl/core/ptes_elapsed_cmp.sv
rtl/core/periodic_task_event_scheduler_unit.sv
test/testbench.sv
